FILE: design/srms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srms_pkg;

    // Default sizes of the block.
    localparam int SRMS_LIST_CAPACITY = 1024;
    localparam int SRMS_REGION_COUNT  = 3;
    localparam int SRMS_ID_WIDTH      = 32;

    // Fixed widths of the channel fields.
    localparam int SRMS_OP_W     = 2;
    localparam int SRMS_REGION_W = 2;
    localparam int SRMS_ID_W     = 32;
    localparam int SRMS_POS_W    = 10;
    localparam int SRMS_STATUS_W = 3;
    localparam int SRMS_COUNT_W  = 11;

    typedef enum logic [SRMS_OP_W-1:0] {
        OP_REMOVE = 2'd0,
        OP_INSERT = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [SRMS_STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_ABSENT  = 3'd1,
        ST_PRESENT = 3'd2,
        ST_FULL    = 3'd3,
        ST_BAD_POS = 3'd4
    } status_t;

    // Where the list memory is read in the next cycle.
    typedef enum logic [1:0] {
        RD_ZERO = 2'd0,
        RD_POS  = 2'd1,
        RD_IDX1 = 2'd2,
        RD_IDX2 = 2'd3
    } rd_sel_t;

    // What is written into the list memory.
    typedef enum logic [1:0] {
        WR_KEY   = 2'd0,
        WR_CARRY = 2'd1,
        WR_RDATA = 2'd2
    } wr_sel_t;

    typedef struct packed {
        logic    capture;
        logic    idx_clr;
        logic    idx_inc;
        logic    wr_en;
        wr_sel_t wr_sel;
        rd_sel_t rd_sel;
        logic    carry_load;
        logic    take_value;
        logic    status_set;
        status_t status;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    out_load;
    } srms_cmd_t;

    typedef struct packed {
        op_t  op;
        logic region_ok;
        logic pos_ok;
        logic at_end;
        logic less;
        logic equal;
        logic full;
        logic del_last;
        logic out_free;
    } srms_flags_t;

endpackage

`default_nettype wire

FILE: design/srms_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module srms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: design/srms_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module srms_ctrl
    import srms_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire srms_flags_t flags,
    output srms_cmd_t        cmd
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_DECODE    = 7'b0000010,
        S_READ_WAIT = 7'b0000100,
        S_SCAN      = 7'b0001000,
        S_SHIFT_INS = 7'b0010000,
        S_SHIFT_DEL = 7'b0100000,
        S_FINISH    = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic is_insert;

    assign is_insert = (flags.op == OP_INSERT);
    assign s_ready   = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = RD_IDX1;
        cmd.wr_sel     = WR_KEY;
        cmd.status     = ST_OK;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_FINISH;
                if (flags.op != OP_NOP) begin
                    if (!flags.region_ok) begin
                        cmd.status_set = 1'b1;
                        cmd.status     = ST_BAD_POS;
                    end else begin
                        unique case (flags.op)
                            OP_READ: begin
                                if (flags.pos_ok) begin
                                    cmd.rd_sel = RD_POS;
                                    state_next = S_READ_WAIT;
                                end else begin
                                    cmd.status_set = 1'b1;
                                    cmd.status     = ST_BAD_POS;
                                end
                            end
                            default: begin
                                cmd.rd_sel  = RD_ZERO;
                                cmd.idx_clr = 1'b1;
                                state_next  = S_SCAN;
                            end
                        endcase
                    end
                end
            end
            S_READ_WAIT: begin
                cmd.take_value = 1'b1;
                state_next     = S_FINISH;
            end
            S_SCAN: begin
                if (flags.at_end) begin
                    state_next = S_FINISH;
                    if (is_insert) begin
                        if (flags.full) begin
                            cmd.status_set = 1'b1;
                            cmd.status     = ST_FULL;
                        end else begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = WR_KEY;
                            cmd.cnt_inc = 1'b1;
                        end
                    end else begin
                        cmd.status_set = 1'b1;
                        cmd.status     = ST_ABSENT;
                    end
                end else if (flags.less) begin
                    cmd.idx_inc = 1'b1;
                end else if (flags.equal) begin
                    if (is_insert) begin
                        cmd.status_set = 1'b1;
                        cmd.status     = ST_PRESENT;
                        state_next     = S_FINISH;
                    end else begin
                        state_next = S_SHIFT_DEL;
                    end
                end else begin
                    if (!is_insert) begin
                        cmd.status_set = 1'b1;
                        cmd.status     = ST_ABSENT;
                        state_next     = S_FINISH;
                    end else if (flags.full) begin
                        cmd.status_set = 1'b1;
                        cmd.status     = ST_FULL;
                        state_next     = S_FINISH;
                    end else begin
                        cmd.wr_en      = 1'b1;
                        cmd.wr_sel     = WR_KEY;
                        cmd.carry_load = 1'b1;
                        cmd.idx_inc    = 1'b1;
                        state_next     = S_SHIFT_INS;
                    end
                end
            end
            S_SHIFT_INS: begin
                cmd.wr_en      = 1'b1;
                cmd.wr_sel     = WR_CARRY;
                cmd.carry_load = 1'b1;
                if (flags.at_end) begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FINISH;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SHIFT_DEL: begin
                if (flags.del_last) begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end else begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = WR_RDATA;
                    cmd.idx_inc = 1'b1;
                    cmd.rd_sel  = RD_IDX2;
                end
            end
            S_FINISH: begin
                if (flags.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/srms_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module srms_dpath
    import srms_pkg::*;
#(
    parameter int LIST_CAPACITY = SRMS_LIST_CAPACITY,
    parameter int REGION_COUNT  = SRMS_REGION_COUNT,
    parameter int ID_WIDTH      = SRMS_ID_WIDTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire srms_cmd_t                   cmd,
    output srms_flags_t                      flags,
    input  wire logic [SRMS_OP_W-1:0]        s_op,
    input  wire logic [SRMS_REGION_W-1:0]    s_region,
    input  wire logic signed [SRMS_ID_W-1:0] s_object_id,
    input  wire logic [SRMS_POS_W-1:0]       s_position,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [SRMS_STATUS_W-1:0]         m_status,
    output logic signed [SRMS_ID_W-1:0]      m_read_value,
    output logic [SRMS_COUNT_W-1:0]          m_count_first,
    output logic [SRMS_COUNT_W-1:0]          m_count_second,
    output logic [SRMS_COUNT_W-1:0]          m_count_third
);

    localparam int DEPTH = LIST_CAPACITY * REGION_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(LIST_CAPACITY + 1);
    localparam int OW    = CW + 1;
    localparam int RIW   = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
    localparam int RSW   = (RIW > SRMS_REGION_W) ? RIW : SRMS_REGION_W;
    localparam int PW    = (CW > SRMS_POS_W) ? CW : SRMS_POS_W;
    localparam logic [AW-1:0] CAP_A = AW'(LIST_CAPACITY);

    op_t                   op_reg;
    logic [RSW-1:0]        region_reg;
    logic [ID_WIDTH-1:0]   key_reg;
    logic [SRMS_POS_W-1:0] pos_reg;
    logic [CW-1:0]         idx_reg;
    logic [ID_WIDTH-1:0]   carry_reg;
    status_t               status_reg;
    logic [SRMS_ID_W-1:0]  value_reg;
    logic [CW-1:0]         count_reg [REGION_COUNT];

    logic                     m_valid_reg;
    logic [SRMS_STATUS_W-1:0] m_status_reg;
    logic [SRMS_ID_W-1:0]     m_value_reg;
    logic [SRMS_COUNT_W-1:0]  m_cnt_reg  [3];
    logic [SRMS_COUNT_W-1:0]  cnt_view   [3];

    logic [RIW-1:0]      region_idx;
    logic [CW-1:0]       n_cur;
    logic [AW-1:0]       base_addr;
    logic [OW-1:0]       rd_off;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [ID_WIDTH-1:0] wr_data;
    logic [ID_WIDTH-1:0] rd_data;

    assign region_idx = region_reg[RIW-1:0];
    assign n_cur      = count_reg[region_idx];
    assign base_addr  = AW'(region_idx) * CAP_A;

    always_comb begin
        case (cmd.rd_sel)
            RD_ZERO: rd_off = '0;
            RD_POS:  rd_off = OW'(pos_reg);
            RD_IDX1: rd_off = OW'(idx_reg) + OW'(1);
            RD_IDX2: rd_off = OW'(idx_reg) + OW'(2);
            default: rd_off = '0;
        endcase
    end

    assign rd_addr = base_addr + AW'(rd_off);
    assign wr_addr = base_addr + AW'(idx_reg);

    always_comb begin
        case (cmd.wr_sel)
            WR_KEY:   wr_data = key_reg;
            WR_CARRY: wr_data = carry_reg;
            WR_RDATA: wr_data = rd_data;
            default:  wr_data = key_reg;
        endcase
    end

    srms_ram #(
        .WIDTH(ID_WIDTH),
        .DEPTH(DEPTH)
    ) u_lists (
        .aclk   (aclk),
        .wr_en  (cmd.wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Item fields and working registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= op_t'(s_op);
            region_reg <= RSW'(s_region);
            key_reg    <= ID_WIDTH'(s_object_id);
            pos_reg    <= s_position;
        end
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (cmd.carry_load) begin
            carry_reg <= rd_data;
        end
        if (cmd.capture) begin
            status_reg <= ST_OK;
            value_reg  <= '0;
        end else begin
            if (cmd.status_set) begin
                status_reg <= cmd.status;
            end
            if (cmd.take_value) begin
                value_reg <= SRMS_ID_W'(rd_data);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < REGION_COUNT; r++) begin
                count_reg[r] <= '0;
            end
        end else if (cmd.cnt_inc) begin
            count_reg[region_idx] <= n_cur + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_reg[region_idx] <= n_cur - CW'(1);
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_cnt
        if (k < REGION_COUNT) begin : g_live
            assign cnt_view[k] = SRMS_COUNT_W'(count_reg[k]);
        end else begin : g_none
            assign cnt_view[k] = '0;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= status_reg;
            m_value_reg  <= value_reg;
            for (int k = 0; k < 3; k++) begin
                m_cnt_reg[k] <= cnt_view[k];
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_read_value   = m_value_reg;
    assign m_count_first  = m_cnt_reg[0];
    assign m_count_second = m_cnt_reg[1];
    assign m_count_third  = m_cnt_reg[2];

    always_comb begin
        flags.op        = op_reg;
        flags.region_ok = (region_reg < RSW'(REGION_COUNT));
        flags.pos_ok    = (PW'(pos_reg) < PW'(n_cur));
        flags.at_end    = (idx_reg == n_cur);
        flags.less      = ($signed(rd_data) < $signed(key_reg));
        flags.equal     = (rd_data == key_reg);
        flags.full      = (n_cur >= CW'(LIST_CAPACITY));
        flags.del_last  = ((OW'(idx_reg) + OW'(1)) == OW'(n_cur));
        flags.out_free  = !m_valid_reg || m_ready;
    end

endmodule

`default_nettype wire

FILE: design/sorted_region_membership_sets_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted region membership sets. For each tracked region the block keeps an
// ascending list of signed object ids in one shared single-write,
// single-read memory with a registered read port. An item removes an id, inserts
// an id at its sorted place, reads the entry at a position, or does nothing;
// every item gives exactly one result with a status and the member counts of the
// first three regions. Items are handled one at a time. A read passes through
// decode, a wait for the registered memory read and a finish state, and its
// result is presented from the output register. An insert or a remove walks the
// region's list once, one entry a cycle: the scan up to the sorted place and the
// following shift of the tail share that single pass. Rejected requests finish
// as soon as the decision is known. The list memory needs no clearing after
// reset, since only entries below a region's count are ever used, so the block
// is ready straight away. A finished result sits in an output register, and the
// next input transfer is taken while it waits.

module sorted_region_membership_sets_top
    import srms_pkg::*;
#(
    parameter int LIST_CAPACITY = SRMS_LIST_CAPACITY,
    parameter int REGION_COUNT  = SRMS_REGION_COUNT,
    parameter int ID_WIDTH      = SRMS_ID_WIDTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [SRMS_OP_W-1:0]        s_op,
    input  wire logic [SRMS_REGION_W-1:0]    s_region,
    input  wire logic signed [SRMS_ID_W-1:0] s_object_id,
    input  wire logic [SRMS_POS_W-1:0]       s_position,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [SRMS_STATUS_W-1:0]         m_status,
    output logic signed [SRMS_ID_W-1:0]      m_read_value,
    output logic [SRMS_COUNT_W-1:0]          m_count_first,
    output logic [SRMS_COUNT_W-1:0]          m_count_second,
    output logic [SRMS_COUNT_W-1:0]          m_count_third
);

    // The controller sequences each item; the datapath holds the lists,
    // the counts and the result register.
    srms_cmd_t   cmd;
    srms_flags_t flags;

    srms_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .flags  (flags),
        .cmd    (cmd)
    );

    srms_dpath #(
        .LIST_CAPACITY(LIST_CAPACITY),
        .REGION_COUNT (REGION_COUNT),
        .ID_WIDTH     (ID_WIDTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .flags         (flags),
        .s_op          (s_op),
        .s_region      (s_region),
        .s_object_id   (s_object_id),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_value  (m_read_value),
        .m_count_first (m_count_first),
        .m_count_second(m_count_second),
        .m_count_third (m_count_third)
    );

endmodule

`default_nettype wire

FILE: design/srms_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module srms_checker
    import srms_pkg::*;
(
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic [SRMS_OP_W-1:0]        s_op,
    input wire logic [SRMS_REGION_W-1:0]    s_region,
    input wire logic signed [SRMS_ID_W-1:0] s_object_id,
    input wire logic [SRMS_POS_W-1:0]       s_position,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [SRMS_STATUS_W-1:0]    m_status,
    input wire logic signed [SRMS_ID_W-1:0] m_read_value,
    input wire logic [SRMS_COUNT_W-1:0]     m_count_first,
    input wire logic [SRMS_COUNT_W-1:0]     m_count_second,
    input wire logic [SRMS_COUNT_W-1:0]     m_count_third
);

    // Counts carried by the last result transfer; all zero after reset.
    logic [SRMS_COUNT_W-1:0] last_first_reg;
    logic [SRMS_COUNT_W-1:0] last_second_reg;
    logic [SRMS_COUNT_W-1:0] last_third_reg;
    logic                    out_xfer;

    assign out_xfer = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_first_reg  <= '0;
            last_second_reg <= '0;
            last_third_reg  <= '0;
        end else if (out_xfer) begin
            last_first_reg  <= m_count_first;
            last_second_reg <= m_count_second;
            last_third_reg  <= m_count_third;
        end
    end

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_read_value)
            && $stable(m_count_first) && $stable(m_count_second)
            && $stable(m_count_third))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in work");

    a_reject_keeps_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer && (m_status != ST_OK) |->
            (m_count_first == last_first_reg) && (m_count_second == last_second_reg)
            && (m_count_third == last_third_reg))
        else $error("rejected request changed a count");

    a_value_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer && (m_read_value != '0) |-> (m_status == ST_OK))
        else $error("read value given with a failing status");

endmodule

bind sorted_region_membership_sets_top srms_checker u_checker (.*);

`default_nettype wire
